// ----- rtl/dss_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dss_pkg
// Shared types, request codes and segment table for the seven-segment scan
// driver.
// ----------------------------------------------------------------------------
package dss_pkg;

    localparam int FRAME_W = 16;
    localparam int BIT_W   = 4;
    localparam int QPTR_W  = 1;
    localparam int QUEUE_DEPTH = 1 << QPTR_W;
    localparam int VAL_W   = 14;
    localparam int PROD_W  = 30;

    localparam logic [1:0] REQ_SET   = 2'd0;
    localparam logic [1:0] REQ_CLEAR = 2'd1;
    localparam logic [1:0] REQ_INIT  = 2'd2;
    localparam logic [1:0] REQ_TICK  = 2'd3;

    localparam logic [3:0]       BLANK_CODE  = 4'hF;
    localparam logic [VAL_W-1:0] MAX_SHOWN   = 14'd9999;
    localparam logic [15:0]      RECIP_TEN   = 16'hCCCD;
    localparam int               RECIP_SHIFT = 19;
    localparam logic [7:0]       SEG_OFF     = 8'hFF;
    localparam logic [7:0]       SEL_NONE    = 8'h00;

    typedef logic [FRAME_W-1:0] frame_t;

    typedef struct packed {
        logic   push;
        frame_t frame;
    } frame_push_t;

    typedef struct packed {
        logic full;
        logic empty;
    } queue_stat_t;

    // active-low segments, dp g f e d c b a
    function automatic logic [7:0] seg_of(input logic [3:0] code);
        logic [7:0] seg;
        case (code)
            4'd0:    seg = 8'hC0;
            4'd1:    seg = 8'hF9;
            4'd2:    seg = 8'hA4;
            4'd3:    seg = 8'hB0;
            4'd4:    seg = 8'h99;
            4'd5:    seg = 8'h92;
            4'd6:    seg = 8'h82;
            4'd7:    seg = 8'hF8;
            4'd8:    seg = 8'h80;
            4'd9:    seg = 8'h90;
            default: seg = SEG_OFF;
        endcase
        return seg;
    endfunction

endpackage

// ----- rtl/seven_segment_scan_driver.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// seven_segment_scan_driver
// Four-digit multiplexed seven-segment driver feeding two chained serial
// shift registers: segment byte, then digit-select byte.
// ----------------------------------------------------------------------------
//   channel   handshake             payload
//   in        in_valid / in_ready   req_type, number, show_zeros
//   out       out_valid / out_ready serial_data, latch_after
//
// init and tick items each give 16 output items, one per cycle without stall.
// set number drops in_ready while the splitter makes one decimal digit per
// cycle, one for each of the DIGIT_COUNT digits; clear does not split.
// a two-frame queue lets input items be taken while bits still shift out;
// when it is full in_ready stays low until the back end starts the next frame.
// reset blanks all digits and sets the scan position to zero.
// ----------------------------------------------------------------------------
module seven_segment_scan_driver #(
    parameter int DIGIT_COUNT = 4
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [1:0]  req_type,
    input  logic [15:0] number,
    input  logic        show_zeros,
    output logic        out_valid,
    input  logic        out_ready,
    output logic        serial_data,
    output logic        latch_after
);

    localparam int POS_W = (DIGIT_COUNT > 1) ? $clog2(DIGIT_COUNT) : 1;

    dss_pkg::frame_push_t push;
    dss_pkg::queue_stat_t stat;
    dss_pkg::frame_t      rd_frame;
    logic                 pop;

    dss_front #(
        .DIGIT_COUNT (DIGIT_COUNT),
        .POS_W       (POS_W)
    ) u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_ready   (in_ready),
        .req_type   (req_type),
        .number     (number),
        .show_zeros (show_zeros),
        .stat       (stat),
        .push       (push)
    );

    dss_queue u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (push),
        .pop      (pop),
        .rd_frame (rd_frame),
        .stat     (stat)
    );

    dss_back u_back (
        .clk         (clk),
        .rst_n       (rst_n),
        .stat        (stat),
        .rd_frame    (rd_frame),
        .pop         (pop),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .serial_data (serial_data),
        .latch_after (latch_after)
    );

endmodule

// ----- rtl/dss_front.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dss_front
// Accepts request items, keeps the digit codes and scan position, splits
// numbers into decimal digits and queues display frames.
// ----------------------------------------------------------------------------
module dss_front #(
    parameter int DIGIT_COUNT = 4,
    parameter int POS_W       = 2
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    output logic                 in_ready,
    input  logic [1:0]           req_type,
    input  logic [15:0]          number,
    input  logic                 show_zeros,
    input  dss_pkg::queue_stat_t stat,
    output dss_pkg::frame_push_t push
);

    localparam logic ST_IDLE  = 1'b0;
    localparam logic ST_SPLIT = 1'b1;

    logic                      state_reg, state_next;
    logic [POS_W-1:0]          scan_reg, scan_next;
    logic [POS_W-1:0]          step_reg, step_next;
    logic [dss_pkg::VAL_W-1:0] val_reg, val_next;
    logic                      lz_reg, lz_next;
    logic                      done_reg, done_next;
    logic [3:0]                digit_reg [DIGIT_COUNT];
    logic [3:0]                digit_next [DIGIT_COUNT];

    logic                       accept;
    logic [dss_pkg::PROD_W-1:0] product;
    logic [dss_pkg::VAL_W-1:0]  quot;
    logic [dss_pkg::VAL_W-1:0]  quot_ten;
    logic [dss_pkg::VAL_W-1:0]  rem_full;
    logic [dss_pkg::VAL_W-1:0]  sat_val;
    logic [7:0]                 sel_byte;

    assign in_ready = (state_reg == ST_IDLE) && !stat.full;
    assign accept   = in_valid && in_ready;

    // divide by ten through the reciprocal, one digit per cycle
    assign product  = dss_pkg::PROD_W'(val_reg) * dss_pkg::PROD_W'(dss_pkg::RECIP_TEN);
    assign quot     = dss_pkg::VAL_W'(product >> dss_pkg::RECIP_SHIFT);
    assign quot_ten = (quot << 3) + (quot << 1);
    assign rem_full = val_reg - quot_ten;

    assign sat_val  = (number > 16'(dss_pkg::MAX_SHOWN)) ? dss_pkg::MAX_SHOWN
                                                         : number[dss_pkg::VAL_W-1:0];
    assign sel_byte = 8'b1 << scan_reg;

    always_comb
    begin
        state_next = state_reg;
        scan_next  = scan_reg;
        step_next  = step_reg;
        val_next   = val_reg;
        lz_next    = lz_reg;
        done_next  = done_reg;
        digit_next = digit_reg;
        push       = '0;
        if (state_reg == ST_IDLE)
        begin
            if (accept)
            begin
                case (req_type)
                    dss_pkg::REQ_SET:
                    begin
                        val_next   = sat_val;
                        lz_next    = show_zeros;
                        step_next  = POS_W'(DIGIT_COUNT - 1);
                        done_next  = 1'b0;
                        state_next = ST_SPLIT;
                    end
                    dss_pkg::REQ_CLEAR:
                    begin
                        for (int i = 0; i < DIGIT_COUNT; i++)
                        begin
                            digit_next[i] = dss_pkg::BLANK_CODE;
                        end
                    end
                    dss_pkg::REQ_INIT:
                    begin
                        for (int i = 0; i < DIGIT_COUNT; i++)
                        begin
                            digit_next[i] = dss_pkg::BLANK_CODE;
                        end
                        push.push  = 1'b1;
                        push.frame = {dss_pkg::SEG_OFF, dss_pkg::SEL_NONE};
                    end
                    dss_pkg::REQ_TICK:
                    begin
                        push.push  = 1'b1;
                        push.frame = {dss_pkg::seg_of(digit_reg[scan_reg]), sel_byte};
                        scan_next  = (scan_reg == POS_W'(DIGIT_COUNT - 1)) ? '0
                                                                         : scan_reg + 1'b1;
                    end
                    default:
                    begin
                    end
                endcase
            end
        end
        else
        begin
            digit_next[step_reg] = done_reg ? dss_pkg::BLANK_CODE : rem_full[3:0];
            val_next = quot;
            if (!lz_reg && (quot == '0))
            begin
                done_next = 1'b1;
            end
            if (step_reg == '0)
            begin
                state_next = ST_IDLE;
            end
            else
            begin
                step_next = step_reg - 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            scan_reg  <= '0;
            for (int i = 0; i < DIGIT_COUNT; i++)
            begin
                digit_reg[i] <= dss_pkg::BLANK_CODE;
            end
        end
        else
        begin
            state_reg <= state_next;
            scan_reg  <= scan_next;
            digit_reg <= digit_next;
        end
    end

    always_ff @(posedge clk)
    begin
        step_reg <= step_next;
        val_reg  <= val_next;
        lz_reg   <= lz_next;
        done_reg <= done_next;
    end

`ifndef SYNTHESIS
    a_split_blocks_input: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_SPLIT) |-> !in_ready)
        else $error("input taken while splitting a number");

    a_tick_advances_scan: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && (req_type == dss_pkg::REQ_TICK) && (DIGIT_COUNT > 1))
            |=> (scan_reg != $past(scan_reg)))
        else $error("scan position did not advance on tick");
`endif

endmodule

// ----- rtl/dss_queue.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dss_queue
// Two-entry frame queue between the request front and the serial back end.
// ----------------------------------------------------------------------------
module dss_queue (
    input  logic                  clk,
    input  logic                  rst_n,
    input  dss_pkg::frame_push_t  push,
    input  logic                  pop,
    output dss_pkg::frame_t       rd_frame,
    output dss_pkg::queue_stat_t  stat
);

    dss_pkg::frame_t             mem_reg [dss_pkg::QUEUE_DEPTH];
    logic [dss_pkg::QPTR_W-1:0]  wr_ptr_reg, wr_ptr_next;
    logic [dss_pkg::QPTR_W-1:0]  rd_ptr_reg, rd_ptr_next;
    logic [dss_pkg::QPTR_W:0]    count_reg, count_next;

    assign stat.full  = (count_reg == (dss_pkg::QPTR_W + 1)'(dss_pkg::QUEUE_DEPTH));
    assign stat.empty = (count_reg == '0);
    assign rd_frame   = mem_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = push.push ? wr_ptr_reg + 1'b1 : wr_ptr_reg;
        rd_ptr_next = pop ? rd_ptr_reg + 1'b1 : rd_ptr_reg;
        count_next  = count_reg + (dss_pkg::QPTR_W + 1)'(push.push)
                                - (dss_pkg::QPTR_W + 1)'(pop);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push.push)
        begin
            mem_reg[wr_ptr_reg] <= push.frame;
        end
    end

`ifndef SYNTHESIS
    a_no_push_full: assert property (@(posedge clk) disable iff (!rst_n)
        push.push |-> !stat.full)
        else $error("frame pushed into full queue");

    a_no_pop_empty: assert property (@(posedge clk) disable iff (!rst_n)
        pop |-> !stat.empty)
        else $error("frame popped from empty queue");
`endif

endmodule

// ----- rtl/dss_back.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dss_back
// Shifts queued frames out one bit per item, MSB first, marking the last bit.
// ----------------------------------------------------------------------------
module dss_back (
    input  logic                 clk,
    input  logic                 rst_n,
    input  dss_pkg::queue_stat_t stat,
    input  dss_pkg::frame_t      rd_frame,
    output logic                 pop,
    output logic                 out_valid,
    input  logic                 out_ready,
    output logic                 serial_data,
    output logic                 latch_after
);

    logic                      busy_reg, busy_next;
    dss_pkg::frame_t           shift_reg, shift_next;
    logic [dss_pkg::BIT_W-1:0] bit_reg, bit_next;

    logic take;
    logic last;

    assign take = busy_reg && out_ready;
    assign last = (bit_reg == dss_pkg::BIT_W'(dss_pkg::FRAME_W - 1));
    assign pop  = !stat.empty && (!busy_reg || (take && last));

    assign out_valid   = busy_reg;
    assign serial_data = shift_reg[dss_pkg::FRAME_W-1];
    assign latch_after = last;

    always_comb
    begin
        busy_next  = busy_reg;
        shift_next = shift_reg;
        bit_next   = bit_reg;
        if (pop)
        begin
            busy_next  = 1'b1;
            shift_next = rd_frame;
            bit_next   = '0;
        end
        else if (take)
        begin
            if (last)
            begin
                busy_next = 1'b0;
            end
            else
            begin
                shift_next = shift_reg << 1;
                bit_next   = bit_reg + 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            bit_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            bit_reg  <= bit_next;
        end
    end

    always_ff @(posedge clk)
    begin
        shift_reg <= shift_next;
    end

`ifndef SYNTHESIS
    a_idle_after_last: assert property (@(posedge clk) disable iff (!rst_n)
        (take && last && stat.empty) |=> !out_valid)
        else $error("output still valid after last bit with nothing queued");
`endif

endmodule

// ----- dv/seven_segment_scan_driver_test.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// seven_segment_scan_driver_test
// Drives set, clear, init and tick requests into the scan driver and checks
// every serial bit and latch strobe against a local model of the digit store
// and scan position. A short directed table comes first, then random traffic
// with bursty input and a stalling output side.
// ----------------------------------------------------------------------------
module seven_segment_scan_driver_test;

    localparam int DIGITS     = 4;
    localparam int RAND_ITEMS = 145;
    localparam logic [79:0] GLYPHS = {8'h90, 8'h80, 8'hF8, 8'h82, 8'h92,
                                      8'h99, 8'hB0, 8'hA4, 8'hF9, 8'hC0};

    typedef struct packed {
        logic data;
        logic latch;
    } shift_bit_t;

    typedef struct packed {
        logic        typed;
        logic [15:0] frame;
    } frame_note_t;

    typedef struct packed {
        logic [1:0]  req;
        logic [15:0] num;
        logic        lz;
        logic        typed;
        logic [15:0] frame;
    } plan_row_t;

    logic        clk            = 1'b0;
    logic        rst_n          = 1'b0;
    logic        in_valid       = 1'b0;
    logic        in_ready;
    logic [1:0]  req_type       = dss_pkg::REQ_SET;
    logic [15:0] number         = 16'd0;
    logic        show_zeros     = 1'b0;
    logic        out_valid;
    logic        out_ready      = 1'b0;
    logic        serial_data;
    logic        latch_after;

    logic [3:0]  shown [DIGITS];
    logic [1:0]  scan_idx;
    shift_bit_t  pending_bits [$];
    frame_note_t frame_notes [$];
    plan_row_t   plan [$];
    int          mismatches  = 0;
    int          burst_left  = 0;
    int          stall_mode  = 0;
    int          stall_left  = 0;
    logic [7:0]  stall_pattern = 8'h5A;

    seven_segment_scan_driver #(
        .DIGIT_COUNT(DIGITS)
    ) i_dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_ready    (in_ready),
        .req_type    (req_type),
        .number      (number),
        .show_zeros  (show_zeros),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .serial_data (serial_data),
        .latch_after (latch_after)
    );

    always #1 clk = ~clk;

    // watchdog
    initial
    begin
        #1_000_000;
        $display("*** FAILED ***");
        $finish;
    end

    // updates the digit store and scan position, returns 1 when a frame goes out
    function automatic logic apply_request(input logic [1:0] req, input logic [15:0] num,
                                           input logic lz, output logic [15:0] frame);
        int         v;
        int         p;
        int         b;
        int         code;
        logic       stop;
        logic [7:0] seg;
        logic [7:0] sel;
        frame = '0;
        apply_request = 1'b0;
        case (req)
            dss_pkg::REQ_SET:
            begin
                v = (num > 16'd9999) ? 9999 : int'(num);
                stop = 1'b0;
                for (p = DIGITS - 1; p >= 0; p--)
                begin
                    if (!stop)
                    begin
                        shown[p] = 4'(v % 10);
                        v = v / 10;
                        if (!lz && v == 0 && p > 0)
                        begin
                            for (b = p - 1; b >= 0; b--)
                                shown[b] = dss_pkg::BLANK_CODE;
                            stop = 1'b1;
                        end
                    end
                end
            end
            dss_pkg::REQ_CLEAR:
            begin
                for (p = 0; p < DIGITS; p++)
                    shown[p] = dss_pkg::BLANK_CODE;
            end
            dss_pkg::REQ_INIT:
            begin
                for (p = 0; p < DIGITS; p++)
                    shown[p] = dss_pkg::BLANK_CODE;
                frame = {dss_pkg::SEG_OFF, dss_pkg::SEL_NONE};
                apply_request = 1'b1;
            end
            dss_pkg::REQ_TICK:
            begin
                code = int'(shown[scan_idx]);
                seg = (code < 10) ? GLYPHS[code*8 +: 8] : dss_pkg::SEG_OFF;
                sel = 8'd1 << scan_idx;
                frame = {seg, sel};
                scan_idx = 2'((int'(scan_idx) + 1) % DIGITS);
                apply_request = 1'b1;
            end
            default:
            begin
            end
        endcase
    endfunction

    always @(posedge clk)
    begin
        shift_bit_t  want;
        frame_note_t note;
        logic        emits;
        logic [15:0] frame;
        int          k;
        if (rst_n)
        begin
            if (out_valid && out_ready)
            begin
                if (pending_bits.size() == 0)
                begin
                    if (mismatches < 10)
                        $display("unexpected output item: data %0b latch %0b",
                                 serial_data, latch_after);
                    mismatches++;
                end
                else
                begin
                    want = pending_bits.pop_front();
                    if (want.data !== serial_data || want.latch !== latch_after)
                    begin
                        if (mismatches < 10)
                            $display({"mismatch at %0t: expected data %0b latch %0b, ",
                                      "got data %0b latch %0b"},
                                     $realtime, want.data, want.latch,
                                     serial_data, latch_after);
                        mismatches++;
                    end
                end
            end
            if (in_valid && in_ready)
            begin
                note = frame_notes.pop_front();
                emits = apply_request(req_type, number, show_zeros, frame);
                if (emits)
                begin
                    if (note.typed)
                        frame = note.frame;
                    for (k = 15; k >= 0; k--)
                        pending_bits.push_back(shift_bit_t'({frame[k], k == 0}));
                end
            end
        end
    end

    // output side: free running, rotating stall pattern, or a full stall
    always @(posedge clk)
    begin
        if (!rst_n)
            out_ready <= 1'b0;
        else if (stall_left == 0)
        begin
            stall_mode = $urandom_range(0, 3);
            stall_left = (stall_mode == 3) ? $urandom_range(2, 10) : $urandom_range(10, 60);
            stall_pattern = 8'($urandom);
            if (stall_pattern == 8'h00)
                stall_pattern = 8'h5A;
            out_ready <= (stall_mode != 3);
        end
        else
        begin
            stall_left--;
            case (stall_mode)
                0: out_ready <= 1'b1;
                3: out_ready <= 1'b0;
                default:
                begin
                    out_ready <= stall_pattern[0];
                    stall_pattern = {stall_pattern[0], stall_pattern[7:1]};
                end
            endcase
        end
    end

    task automatic send_item(input logic [1:0] req, input logic [15:0] num, input logic lz,
                             input logic typed, input logic [15:0] frame);
        frame_note_t note;
        note.typed = typed;
        note.frame = frame;
        frame_notes.push_back(note);
        in_valid   <= 1'b1;
        req_type   <= req;
        number     <= num;
        show_zeros <= lz;
        @(posedge clk);
        while (!(in_valid && in_ready))
            @(posedge clk);
    endtask

    task automatic pace();
        int gap;
        if (burst_left > 0)
            burst_left--;
        else
        begin
            gap = $urandom_range(1, 12);
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
            burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(20, 40)
                                                     : $urandom_range(1, 8);
        end
    endtask

    task automatic hold_until_empty();
        in_valid <= 1'b0;
        while (pending_bits.size() != 0)
            @(posedge clk);
        repeat (DIGITS + 4) @(posedge clk);
    endtask

    initial
    begin
        int          i;
        int          pick;
        logic [1:0]  req;
        logic [15:0] num;
        for (i = 0; i < DIGITS; i++)
            shown[i] = dss_pkg::BLANK_CODE;
        scan_idx = 2'd0;
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        //              req                 number       lz    typed frame
        plan.push_back({dss_pkg::REQ_TICK,  16'd0,     1'b0, 1'b1, 16'hFF01});
        plan.push_back({dss_pkg::REQ_TICK,  16'd0,     1'b0, 1'b1, 16'hFF02});
        plan.push_back({dss_pkg::REQ_SET,   16'd0,     1'b0, 1'b0, 16'h0000});
        plan.push_back({dss_pkg::REQ_TICK,  16'd0,     1'b0, 1'b0, 16'h0000});
        plan.push_back({dss_pkg::REQ_TICK,  16'd0,     1'b0, 1'b0, 16'h0000});
        plan.push_back({dss_pkg::REQ_SET,   16'hFFFF,  1'b0, 1'b0, 16'h0000});
        plan.push_back({dss_pkg::REQ_TICK,  16'd0,     1'b0, 1'b1, 16'h9001});
        plan.push_back({dss_pkg::REQ_TICK,  16'd0,     1'b0, 1'b1, 16'h9002});
        plan.push_back({dss_pkg::REQ_TICK,  16'd0,     1'b0, 1'b1, 16'h9004});
        plan.push_back({dss_pkg::REQ_TICK,  16'd0,     1'b0, 1'b1, 16'h9008});
        plan.push_back({dss_pkg::REQ_SET,   16'd10000, 1'b1, 1'b0, 16'h0000});
        plan.push_back({dss_pkg::REQ_SET,   16'd7,     1'b1, 1'b0, 16'h0000});
        plan.push_back({dss_pkg::REQ_TICK,  16'd0,     1'b0, 1'b0, 16'h0000});
        plan.push_back({dss_pkg::REQ_TICK,  16'd0,     1'b0, 1'b0, 16'h0000});
        plan.push_back({dss_pkg::REQ_TICK,  16'd0,     1'b0, 1'b0, 16'h0000});
        plan.push_back({dss_pkg::REQ_TICK,  16'd0,     1'b0, 1'b0, 16'h0000});
        plan.push_back({dss_pkg::REQ_SET,   16'd1000,  1'b0, 1'b0, 16'h0000});
        plan.push_back({dss_pkg::REQ_TICK,  16'd0,     1'b0, 1'b0, 16'h0000});
        plan.push_back({dss_pkg::REQ_CLEAR, 16'hFFFF,  1'b1, 1'b0, 16'h0000});
        plan.push_back({dss_pkg::REQ_TICK,  16'd0,     1'b0, 1'b0, 16'h0000});
        plan.push_back({dss_pkg::REQ_SET,   16'd45,    1'b0, 1'b0, 16'h0000});
        plan.push_back({dss_pkg::REQ_TICK,  16'd0,     1'b0, 1'b0, 16'h0000});
        plan.push_back({dss_pkg::REQ_INIT,  16'hFFFF,  1'b1, 1'b1, 16'hFF00});
        plan.push_back({dss_pkg::REQ_TICK,  16'd0,     1'b0, 1'b1, 16'hFF08});
        plan.push_back({dss_pkg::REQ_SET,   16'd9999,  1'b0, 1'b0, 16'h0000});

        foreach (plan[i])
        begin
            send_item(plan[i].req, plan[i].num, plan[i].lz, plan[i].typed, plan[i].frame);
            pace();
        end
        hold_until_empty();

        for (i = 0; i < RAND_ITEMS; i++)
        begin
            pick = $urandom_range(0, 9);
            if (pick < 3)
                req = dss_pkg::REQ_SET;
            else if (pick == 3)
                req = dss_pkg::REQ_CLEAR;
            else if (pick == 4)
                req = dss_pkg::REQ_INIT;
            else
                req = dss_pkg::REQ_TICK;
            case ($urandom_range(0, 5))
                0: num = 16'd0;
                1: num = 16'($urandom_range(0, 9));
                2: num = 16'($urandom_range(0, 99));
                3: num = 16'($urandom_range(0, 999));
                4: num = 16'($urandom_range(0, 9999));
                default: num = 16'($urandom);
            endcase
            send_item(req, num, 1'($urandom), 1'b0, 16'h0000);
            if (i % 50 == 49)
                hold_until_empty();
            else
                pace();
        end
        in_valid <= 1'b0;

        while (pending_bits.size() != 0)
            @(posedge clk);
        repeat (40) @(posedge clk);
        if (mismatches == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

endmodule

// ----- sim.f -----
rtl/dss_pkg.sv
rtl/dss_front.sv
rtl/dss_queue.sv
rtl/dss_back.sv
rtl/seven_segment_scan_driver.sv
dv/seven_segment_scan_driver_test.sv
